// ===== rtl/core/tsm_pkg.sv =====
package tsm_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = ADDR_W + 1;
	localparam int VALUE_W     = 32;
	localparam int FRAC_W      = 16;
	localparam int TAG_W       = 2;
	localparam int ENTRY_W     = TAG_W + VALUE_W;
	localparam int QUO_W       = VALUE_W + FRAC_W;
	localparam int CNT_W       = $clog2(QUO_W + 1);
	localparam int IN_W        = 40;
	localparam int OUT_W       = 40;

	localparam logic [3:0] OP_LOAD = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_MUL  = 4'd3;
	localparam logic [3:0] OP_DIV  = 4'd4;
	localparam logic [3:0] OP_POP  = 4'd5;
	localparam logic [3:0] OP_HALT = 4'd6;
	localparam logic [3:0] OP_RET  = 4'd7;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_TYPE    = 3'd1;
	localparam logic [2:0] STS_DIVZERO = 3'd2;
	localparam logic [2:0] STS_UNKNOWN = 3'd3;
	localparam logic [2:0] STS_UNDER   = 3'd4;
	localparam logic [2:0] STS_OVER    = 3'd5;

	localparam logic [TAG_W-1:0] TAG_NIL    = 2'd0;
	localparam logic [TAG_W-1:0] TAG_NUMBER = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RDB,
		ST_RDA,
		ST_BUSY,
		ST_FIN
	} seq_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_DONE
	} md_state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_ctl_t;

endpackage

// ===== rtl/core/tsm_ram.sv =====
module tsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/tsm_muldiv.sv =====
module tsm_muldiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsm_pkg::md_ctl_t             ctl,
	input  logic [tsm_pkg::VALUE_W-1:0]  op_a,
	input  logic [tsm_pkg::VALUE_W-1:0]  op_b,
	output logic                         done,
	output logic [tsm_pkg::VALUE_W-1:0]  result
);
	import tsm_pkg::*;

	md_state_t          state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               div_q;
	logic [VALUE_W-1:0] x_q;
	logic [VALUE_W-1:0] acc_q;
	logic [QUO_W-1:0]   w_q;

	logic [VALUE_W-1:0] mag_a;
	logic [VALUE_W-1:0] mag_b;
	logic [VALUE_W:0]   mul_sum;
	logic [VALUE_W:0]   div_rem;
	logic [VALUE_W:0]   div_diff;
	logic               div_ge;
	logic [QUO_W-1:0]   quo;
	logic               pos_ovf;
	logic               neg_ovf;

	assign mag_a = op_a[VALUE_W-1] ? (~op_a + 1'b1) : op_a;
	assign mag_b = op_b[VALUE_W-1] ? (~op_b + 1'b1) : op_b;

	// one multiplier bit per cycle: shift-add
	assign mul_sum = {1'b0, acc_q} + (w_q[0] ? {1'b0, x_q} : '0);

	// one quotient bit per cycle: restoring divide
	assign div_rem  = {acc_q, w_q[QUO_W-1]};
	assign div_diff = div_rem - {1'b0, x_q};
	assign div_ge   = (div_rem >= {1'b0, x_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				MD_IDLE: begin
					if (ctl.start) begin
						state_q <= MD_RUN;
						cnt_q   <= ctl.is_div ? CNT_W'(QUO_W) : CNT_W'(VALUE_W);
					end
				end
				MD_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= MD_DONE;
					end
				end
				MD_DONE: state_q <= MD_IDLE;
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	// operand and shift registers
	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && ctl.start) begin
			neg_q <= op_a[VALUE_W-1] ^ op_b[VALUE_W-1];
			div_q <= ctl.is_div;
			acc_q <= '0;
			if (ctl.is_div) begin
				x_q <= mag_b;
				w_q <= {mag_a, {FRAC_W{1'b0}}};
			end else begin
				x_q <= mag_a;
				w_q <= {{FRAC_W{1'b0}}, mag_b};
			end
		end else if (state_q == MD_RUN) begin
			if (div_q) begin
				acc_q <= div_ge ? div_diff[VALUE_W-1:0] : div_rem[VALUE_W-1:0];
				w_q   <= {w_q[QUO_W-2:0], div_ge};
			end else begin
				acc_q <= mul_sum[VALUE_W:1];
				w_q   <= {w_q[QUO_W-1:VALUE_W], mul_sum[0], w_q[VALUE_W-1:1]};
			end
		end
	end

	// magnitude result (product or quotient), then sign and saturation
	assign quo     = div_q ? w_q : {acc_q, w_q[VALUE_W-1:FRAC_W]};
	assign pos_ovf = |quo[QUO_W-1:VALUE_W-1];
	assign neg_ovf = (|quo[QUO_W-1:VALUE_W]) | (quo[VALUE_W-1] & (|quo[VALUE_W-2:0]));

	always_comb begin
		if (neg_q) begin
			result = neg_ovf ? {1'b1, {(VALUE_W-1){1'b0}}} : (~quo[VALUE_W-1:0] + 1'b1);
		end else begin
			result = pos_ovf ? {1'b0, {(VALUE_W-1){1'b1}}} : quo[VALUE_W-1:0];
		end
	end

	assign done = (state_q == MD_DONE);

endmodule

// ===== rtl/core/typed_stack_machine_executor.sv =====
// Typed stack machine executor.
// Input stream s_*: one bytecode instruction per item (opcode, constant tag,
// constant payload). Output stream m_*: one result item when a program ends
// (halt/return with the popped value) or fails (type error, divide by zero,
// unknown opcode, stack underflow or overflow); the stack is emptied then.
// The stack (64 tagged entries) sits in a RAM with one write port and one
// registered read port, so operands are fetched one per cycle. Mul and div
// run in a shared bit-serial unit, one product or quotient bit per cycle.
// A new item is taken only while no item is in work; s_tready is low
// otherwise. A result sits in an output register until m_tready takes it,
// and the next items are accepted meanwhile; only a second result waits in
// the block for the register to free.
// Reset empties the stack and drops any pending result. Stack entries are
// not cleared, as only written entries are ever read.
module typed_stack_machine_executor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [tsm_pkg::IN_W-1:0]  s_tdata,  // opcode[3:0], operand_type[5:4], operand_value[37:6]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [tsm_pkg::OUT_W-1:0] m_tdata   // status[2:0], result_type[4:3], result_value[36:5]
);
	import tsm_pkg::*;

	seq_state_t         state_q, state_d;
	logic [SP_W-1:0]    sp_q, sp_d;
	logic [SP_W-1:0]    sp_m1, sp_m2;
	logic [3:0]         op_q;
	logic [TAG_W-1:0]   tag_q;
	logic [VALUE_W-1:0] val_q;
	logic [ENTRY_W-1:0] b_q;
	logic               b_load;
	logic [2:0]         fin_sts_q, fin_sts_d;
	logic [TAG_W-1:0]   fin_tag_q, fin_tag_d;
	logic [VALUE_W-1:0] fin_val_q, fin_val_d;
	logic               fin_load;
	logic               out_load;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	md_ctl_t            md_ctl;
	logic               md_done;
	logic [VALUE_W-1:0] md_result;

	logic [VALUE_W-1:0] a_val, b_val;
	logic [VALUE_W:0]   add_sum, sub_dif;
	logic [VALUE_W-1:0] add_sat, sub_sat;
	logic               tags_ok;

	assign sp_m1 = sp_q - 1'b1;
	assign sp_m2 = sp_q - SP_W'(2);

	tsm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tsm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.op_a   (a_val),
		.op_b   (b_val),
		.done   (md_done),
		.result (md_result)
	);

	// operands: a from the RAM read, b captured from the read before it
	assign a_val   = ram_rdata[VALUE_W-1:0];
	assign b_val   = b_q[VALUE_W-1:0];
	assign tags_ok = (ram_rdata[ENTRY_W-1:VALUE_W] == TAG_NUMBER) &&
	                 (b_q[ENTRY_W-1:VALUE_W] == TAG_NUMBER);

	// saturating add and subtract
	assign add_sum = {a_val[VALUE_W-1], a_val} + {b_val[VALUE_W-1], b_val};
	assign sub_dif = {a_val[VALUE_W-1], a_val} - {b_val[VALUE_W-1], b_val};
	assign add_sat = (add_sum[VALUE_W] != add_sum[VALUE_W-1]) ?
	                 {add_sum[VALUE_W], {(VALUE_W-1){~add_sum[VALUE_W]}}} :
	                 add_sum[VALUE_W-1:0];
	assign sub_sat = (sub_dif[VALUE_W] != sub_dif[VALUE_W-1]) ?
	                 {sub_dif[VALUE_W], {(VALUE_W-1){~sub_dif[VALUE_W]}}} :
	                 sub_dif[VALUE_W-1:0];

	assign s_tready = (state_q == ST_IDLE);

	// sequencer: next state, stack access, result capture
	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		ram_we    = 1'b0;
		ram_waddr = sp_q[ADDR_W-1:0];
		ram_wdata = {tag_q, val_q};
		ram_re    = 1'b0;
		ram_raddr = sp_m1[ADDR_W-1:0];
		b_load    = 1'b0;
		fin_load  = 1'b0;
		fin_sts_d = STS_OK;
		fin_tag_d = TAG_NIL;
		fin_val_d = '0;
		out_load  = 1'b0;
		md_ctl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (op_q)
					OP_LOAD: begin
						if (sp_q[ADDR_W]) begin
							fin_load  = 1'b1;
							fin_sts_d = STS_OVER;
							state_d   = ST_FIN;
						end else begin
							ram_we  = 1'b1;
							sp_d    = sp_q + 1'b1;
							state_d = ST_IDLE;
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						if (sp_q < SP_W'(2)) begin
							fin_load  = 1'b1;
							fin_sts_d = STS_UNDER;
							state_d   = ST_FIN;
						end else begin
							ram_re  = 1'b1;
							state_d = ST_RDB;
						end
					end
					OP_POP: begin
						if (sp_q == '0) begin
							fin_load  = 1'b1;
							fin_sts_d = STS_UNDER;
							state_d   = ST_FIN;
						end else begin
							sp_d    = sp_m1;
							state_d = ST_IDLE;
						end
					end
					OP_HALT, OP_RET: begin
						if (sp_q == '0) begin
							fin_load  = 1'b1;
							fin_sts_d = STS_UNDER;
							state_d   = ST_FIN;
						end else begin
							ram_re  = 1'b1;
							state_d = ST_RDB;
						end
					end
					default: begin
						fin_load  = 1'b1;
						fin_sts_d = STS_UNKNOWN;
						state_d   = ST_FIN;
					end
				endcase
			end
			ST_RDB: begin
				if (op_q == OP_HALT || op_q == OP_RET) begin
					fin_load  = 1'b1;
					fin_sts_d = STS_OK;
					fin_tag_d = ram_rdata[ENTRY_W-1:VALUE_W];
					fin_val_d = ram_rdata[VALUE_W-1:0];
					state_d   = ST_FIN;
				end else begin
					b_load    = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = sp_m2[ADDR_W-1:0];
					state_d   = ST_RDA;
				end
			end
			ST_RDA: begin
				ram_waddr = sp_m2[ADDR_W-1:0];
				if (!tags_ok) begin
					fin_load  = 1'b1;
					fin_sts_d = STS_TYPE;
					state_d   = ST_FIN;
				end else if (op_q == OP_ADD || op_q == OP_SUB) begin
					ram_we    = 1'b1;
					ram_wdata = {TAG_NUMBER, (op_q == OP_ADD) ? add_sat : sub_sat};
					sp_d      = sp_m1;
					state_d   = ST_IDLE;
				end else if (op_q == OP_DIV && b_val == '0) begin
					fin_load  = 1'b1;
					fin_sts_d = STS_DIVZERO;
					state_d   = ST_FIN;
				end else begin
					md_ctl.start  = 1'b1;
					md_ctl.is_div = (op_q == OP_DIV);
					state_d       = ST_BUSY;
				end
			end
			ST_BUSY: begin
				ram_waddr = sp_m2[ADDR_W-1:0];
				ram_wdata = {TAG_NUMBER, md_result};
				if (md_done) begin
					ram_we  = 1'b1;
					sp_d    = sp_m1;
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					sp_d     = '0;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, operand and result registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tdata[3:0];
			tag_q <= s_tdata[5:4];
			val_q <= s_tdata[37:6];
		end
		if (b_load) begin
			b_q <= ram_rdata;
		end
		if (fin_load) begin
			fin_sts_q <= fin_sts_d;
			fin_tag_q <= fin_tag_d;
			fin_val_q <= fin_val_d;
		end
		if (out_load) begin
			out_data_q <= {3'b000, fin_val_q, fin_tag_q, fin_sts_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	// the stack never holds more than its depth
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// a reported result empties the stack
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (sp_q == '0 && m_tvalid))
		else $error("stack not emptied after result");

	// the serial unit finishes only while the sequencer waits on it
	a_md_owner: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == ST_BUSY))
		else $error("mul/div done outside busy state");

	// a mul or div pops exactly one entry net
	a_binop_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY && md_done) |=> (sp_q == $past(sp_m1)))
		else $error("stack pointer wrong after mul/div");
`endif

endmodule

// ===== tb/tsm_checker.sv =====
module tsm_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [tsm_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [tsm_pkg::OUT_W-1:0] m_tdata,
	output int                        errors,
	output int                        pending,
	output int                        checked
);
	import tsm_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  tag;
		logic [31:0] value;
	} outcome_t;

	// model copy of the stack
	logic [1:0]  shadow_tags [STACK_DEPTH];
	logic [31:0] shadow_vals [STACK_DEPTH];
	int          shadow_sp;
	outcome_t    outcomes_due [$];

	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;

	function automatic logic [31:0] clamp(input longint v);
		if (v > MAXV) return MAXV[31:0];
		if (v < MINV) return MINV[31:0];
		return v[31:0];
	endfunction

	// apply sign to an unsigned magnitude, saturating
	function automatic logic [31:0] signed_sat(input logic [63:0] q, input bit neg);
		if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [31:0] v);
		longint w;
		w = v;
		return (w < 0) ? -w : w;
	endfunction

	// executes one instruction; returns 1 when it yields an outcome
	function automatic bit execute(input logic [3:0] op, input logic [1:0] tg,
			input logic [31:0] v, output outcome_t r);
		logic signed [31:0] a, b;
		logic [31:0] res;
		bit neg;
		r = '0;
		case (op)
			OP_LOAD: begin
				if (shadow_sp >= STACK_DEPTH) begin
					r.status = STS_OVER;
					shadow_sp = 0;
					return 1;
				end
				shadow_tags[shadow_sp] = tg;
				shadow_vals[shadow_sp] = v;
				shadow_sp++;
				return 0;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (shadow_sp < 2) begin
					r.status = STS_UNDER;
					shadow_sp = 0;
					return 1;
				end
				b = shadow_vals[shadow_sp-1];
				a = shadow_vals[shadow_sp-2];
				if (shadow_tags[shadow_sp-1] != TAG_NUMBER
						|| shadow_tags[shadow_sp-2] != TAG_NUMBER) begin
					r.status = STS_TYPE;
					shadow_sp = 0;
					return 1;
				end
				neg = (a < 0) != (b < 0);
				case (op)
					OP_ADD: res = clamp(longint'(a) + longint'(b));
					OP_SUB: res = clamp(longint'(a) - longint'(b));
					OP_MUL: res = signed_sat((magnitude(a) * magnitude(b)) >> FRAC_W, neg);
					default: begin
						if (b == 0) begin
							r.status = STS_DIVZERO;
							shadow_sp = 0;
							return 1;
						end
						res = signed_sat((magnitude(a) << FRAC_W) / magnitude(b), neg);
					end
				endcase
				shadow_sp--;
				shadow_tags[shadow_sp-1] = TAG_NUMBER;
				shadow_vals[shadow_sp-1] = res;
				return 0;
			end
			OP_POP, OP_HALT, OP_RET: begin
				if (shadow_sp == 0) begin
					r.status = STS_UNDER;
					shadow_sp = 0;
					return 1;
				end
				if (op == OP_POP) begin
					shadow_sp--;
					return 0;
				end
				r.status = STS_OK;
				r.tag    = shadow_tags[shadow_sp-1];
				r.value  = shadow_vals[shadow_sp-1];
				shadow_sp = 0;
				return 1;
			end
			default: begin
				r.status = STS_UNKNOWN;
				shadow_sp = 0;
				return 1;
			end
		endcase
	endfunction

	initial begin
		errors = 0;
		checked = 0;
		shadow_sp = 0;
	end

	assign pending = outcomes_due.size();

	// predict on every accepted instruction
	always @(posedge clk) begin
		outcome_t r;
		if (arst_n && s_tvalid && s_tready)
			if (execute(s_tdata[3:0], s_tdata[5:4], s_tdata[37:6], r))
				outcomes_due.push_back(r);
	end

	// compare every accepted result item with the oldest prediction
	always @(posedge clk) begin
		outcome_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[4:3], m_tdata[36:5]};
			checked++;
			if (outcomes_due.size() == 0) begin
				$display("%0t: unexpected result status=%0d tag=%0d value=%h",
					$time, got.status, got.tag, got.value);
				errors++;
			end else begin
				want = outcomes_due.pop_front();
				if (want !== got) begin
					$display("%0t: expected status=%0d tag=%0d value=%h, got status=%0d tag=%0d value=%h",
						$time, want.status, want.tag, want.value,
						got.status, got.tag, got.value);
					errors++;
				end
			end
		end
	end
endmodule

// ===== tb/tb.sv =====
module tb;
	import tsm_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	int errors, pending, checked;
	int issued = 0;
	bit calm = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	typed_stack_machine_executor dut (.*);

	tsm_checker chk (.*);

	// result side stalls in bursts
	always begin
		@(posedge clk);
		if (!calm && $urandom_range(0, 9) == 0) begin
			m_tready <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		m_tready <= 1;
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 4000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic issue(input logic [3:0] op, input logic [1:0] tg, input logic [31:0] v);
		s_tdata  <= {2'b00, v, tg, op};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		issued++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_number();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom;
			4: return $urandom_range(0, 32'h3_ffff);
			5: return -$urandom_range(0, 32'h3_ffff);
			default: return ($urandom_range(0, 200) - 100) << FRAC_W;
		endcase
	endfunction

	// well-formed program with random content, sometimes broken
	task automatic run_program();
		int depth;
		logic [3:0] op;
		depth = $urandom_range(1, 6);
		for (int i = 0; i < depth; i++) begin
			if ($urandom_range(0, 19) == 0)
				issue(OP_LOAD, 2'($urandom_range(0, 3)), $urandom);
			else issue(OP_LOAD, TAG_NUMBER, pick_number());
		end
		for (int i = 1; i < depth; i++) begin
			op = OP_ADD + 4'($urandom_range(0, 3));
			if ($urandom_range(0, 29) == 0) op = OP_POP;
			if ($urandom_range(0, 49) == 0) op = 4'(8 + $urandom_range(0, 7));
			issue(op, 2'($urandom_range(0, 3)), $urandom);
		end
		issue($urandom_range(0, 1) ? OP_HALT : OP_RET, 2'($urandom_range(0, 3)), $urandom);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: underflow on each op, unknown opcodes
		for (int op = OP_ADD; op <= OP_RET; op++) issue(4'(op), 2'd3, 32'hffff_ffff);
		issue(4'd8, 2'd0, 32'h0);
		issue(4'd15, 2'd3, 32'hffff_ffff);
		// typed constants returned as given
		issue(OP_LOAD, 2'd3, 32'h8000_0000);
		issue(OP_RET, 2'd0, 32'h0);
		// type error, then divide by zero
		issue(OP_LOAD, 2'd1, 32'h1);
		issue(OP_LOAD, TAG_NUMBER, 32'h0001_0000);
		issue(OP_ADD, 2'd0, 32'h0);
		issue(OP_LOAD, TAG_NUMBER, 32'h7fff_ffff);
		issue(OP_LOAD, TAG_NUMBER, 32'h0);
		issue(OP_DIV, 2'd0, 32'h0);
		// saturating multiply of the extremes
		issue(OP_LOAD, TAG_NUMBER, 32'h8000_0000);
		issue(OP_LOAD, TAG_NUMBER, 32'h8000_0000);
		issue(OP_MUL, 2'd0, 32'h0);
		issue(OP_HALT, 2'd0, 32'h0);
		// fill the stack, then one load too many
		for (int i = 0; i <= STACK_DEPTH; i++) issue(OP_LOAD, i[1:0], $urandom);

		// drain before going random
		s_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		while (issued < 950) begin
			if (issued > 800) calm = 1;
			if ($urandom_range(0, 5) == 0)
				issue(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), $urandom);
			else
				run_program();
		end
		s_tvalid <= 0;

		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Ran %0d instructions: arithmetic, typed loads, stack limits and all error codes.",
			issued);
		$display("Compared %0d result items against the model.", checked);
		if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
